// ===== hw/rtl/adsr_pkg.sv =====
`default_nettype none

package adsr_pkg;

    // field and register widths
    localparam int unsigned FIELD_W        = 16;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned COUNT_BITS_DEF = 16;

    // unity gain in q1.15
    localparam logic [FIELD_W-1:0] ONE_Q15 = 16'h8000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd4;

    // register reset values
    localparam logic [FIELD_W-1:0] RST_TOTAL   = 16'd6615;
    localparam logic [FIELD_W-1:0] RST_ATTACK  = 16'd882;
    localparam logic [FIELD_W-1:0] RST_DECAY   = 16'd1764;
    localparam logic [FIELD_W-1:0] RST_RELEASE = 16'd3969;
    localparam logic [FIELD_W-1:0] RST_SUSTAIN = 16'd22938;

    // serial divider: one quotient bit per cycle
    localparam int unsigned NUM_W      = 31;
    localparam int unsigned DIV_STEPS  = 16;
    localparam int unsigned DIV_CNT_W  = 4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/adsr_div.sv =====
`default_nettype none

module adsr_div
    import adsr_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [NUM_W-1:0]   i_num,
    input  wire logic [FIELD_W-1:0] i_den,
    output t_div_stat               o_stat,
    output logic [FIELD_W-1:0]      o_quot
);

    // restoring division; numerator is always below den * 2^16
    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [FIELD_W-1:0]   r_rem;
    logic [FIELD_W-1:0]   r_nq;
    logic [FIELD_W-1:0]   r_den;

    logic [FIELD_W:0]     w_trial;
    logic [FIELD_W:0]     w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_nq[FIELD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_busy <= (r_cnt != '0);
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    // numerator low bits shift out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num[NUM_W-1:FIELD_W]};
            r_nq  <= i_num[FIELD_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[FIELD_W-1:0] : w_trial[FIELD_W-1:0];
            r_nq  <= {r_nq[FIELD_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == '0);
    assign o_quot      = r_nq;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");

    a_busy_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_cnt != '0) && !i_start) |=> r_busy)
        else $error("divider stopped early");

endmodule

`default_nettype wire

// ===== hw/rtl/adsr_envelope_shaper_core.sv =====
// adsr envelope shaper: each accepted beat carries a signed 16-bit sample and a restart flag;
// the block returns one beat with the sample scaled by a linear attack-decay-sustain-release
// gain (q1.15) chosen by the sample's position in the sound, truncated toward zero, and a
// last flag on the final sample. when the gain needs a division (attack, decay, release) the
// item waits on the 16-step bit-serial divider; in sustain or once the release has run out
// the division is skipped. the result sits in an output register, so the next beat is taken
// while it waits. the user must write configuration only while the block is idle; the block
// itself does not enforce this.
`default_nettype none

module adsr_envelope_shaper_core
    import adsr_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [FIELD_W-1:0]    i_cfg_wdata,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic signed [FIELD_W-1:0] i_sample_in,
    input  wire logic                  i_restart,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic signed [FIELD_W-1:0]  o_sample_out,
    output logic                       o_last
);

    // compare width: wide enough for the position plus one and for a + d + s
    localparam int unsigned CMP_W = (COUNT_BITS + 1 > FIELD_W + 1) ? COUNT_BITS + 1
                                                                     : FIELD_W + 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SUM  = 8'b0000_0010,
        S_ADS  = 8'b0000_0100,
        S_SEL  = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_OMUL = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [FIELD_W-1:0] r_total, r_attack, r_decay, r_release, r_sustain;
    logic [FIELD_W-1:0] w_level;

    // position counter and per-item state
    logic [COUNT_BITS-1:0] r_pos;
    logic [COUNT_BITS-1:0] r_x;
    logic                  r_neg;
    logic [FIELD_W-1:0]    r_mag;
    logic                  r_last;

    // phase boundaries
    logic [FIELD_W:0]      r_ad;
    logic [FIELD_W+1:0]    r_adr;
    logic [FIELD_W:0]      r_ads;

    // operands picked for the current phase
    logic [FIELD_W-1:0]    r_ma, r_mb, r_den, r_env;
    logic                  r_dec, r_skip;

    logic [FIELD_W-1:0]    r_pm;
    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_sample_out;
    logic                  r_last_out;

    // accept side
    logic                  w_in_acc;
    logic [COUNT_BITS-1:0] w_cur_i;
    logic                  w_acc_last;

    // phase select
    logic [CMP_W-1:0]      w_x;
    logic [CMP_W-1:0]      w_k;
    logic                  w_in_att, w_in_dec, w_in_sus, w_rel_zero;

    // shared multiplier
    logic [FIELD_W-1:0]    w_mul_a, w_mul_b;
    logic [NUM_W-1:0]      w_prod;
    logic [FIELD_W-1:0]    w_env_sel;

    // divider
    logic                  w_div_start;
    t_div_stat             w_div_stat;
    logic [FIELD_W-1:0]    w_quot;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // saturate sustain level at unity
    assign w_level = (r_sustain > ONE_Q15) ? ONE_Q15 : r_sustain;

    // position of this sample and end-of-sound test
    assign w_cur_i    = i_restart ? '0 : r_pos;
    assign w_acc_last = (CMP_W'(w_cur_i) + CMP_W'(1)) >= CMP_W'(r_total);

    // phase decision
    assign w_x        = CMP_W'(r_x);
    assign w_in_att   = w_x < CMP_W'(r_attack);
    assign w_in_dec   = w_x < CMP_W'(r_ad);
    assign w_in_sus   = w_x < CMP_W'(r_ads);
    assign w_k        = w_x - CMP_W'(r_ads);
    assign w_rel_zero = (r_release == '0) || (w_k >= CMP_W'(r_release));

    // envelope after division: decay counts down from unity
    assign w_env_sel = r_skip ? r_env : (r_dec ? (ONE_Q15 - w_quot) : w_quot);

    // one multiplier, used for the numerator and for the final scaling
    assign w_mul_a = (r_state == S_MUL) ? r_ma : r_mag;
    assign w_mul_b = (r_state == S_MUL) ? r_mb : w_env_sel;
    assign w_prod  = NUM_W'(32'(w_mul_a) * 32'(w_mul_b));

    assign w_div_start = (r_state == S_MUL);

    adsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_den),
        .o_stat  (w_div_stat),
        .o_quot  (w_quot)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= RST_TOTAL;
            r_attack  <= RST_ATTACK;
            r_decay   <= RST_DECAY;
            r_release <= RST_RELEASE;
            r_sustain <= RST_SUSTAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOTAL:   r_total   <= i_cfg_wdata;
                CFG_ATTACK:  r_attack  <= i_cfg_wdata;
                CFG_DECAY:   r_decay   <= i_cfg_wdata;
                CFG_RELEASE: r_release <= i_cfg_wdata;
                CFG_SUSTAIN: r_sustain <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_SUM;
            S_SUM:  n_state = S_ADS;
            S_ADS:  n_state = S_SEL;
            // sustain and a spent release need no division
            S_SEL:  n_state = (!w_in_att && !w_in_dec && (w_in_sus || w_rel_zero))
                              ? S_OMUL : S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (w_div_stat.done) n_state = S_OMUL;
            S_OMUL: n_state = S_DONE;
            // wait for the output register to free up
            S_DONE: if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                // position wraps at the counter width and restarts after the last sample
                r_pos <= w_acc_last ? '0 : COUNT_BITS'(w_cur_i + 1'b1);
            end
        end
    end

    // per-item datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_x    <= w_cur_i;
                    r_neg  <= i_sample_in[FIELD_W-1];
                    r_mag  <= i_sample_in[FIELD_W-1]
                              ? FIELD_W'(FIELD_W'(0) - $unsigned(i_sample_in))
                              : $unsigned(i_sample_in);
                    r_last <= w_acc_last;
                end
            end
            S_SUM: begin
                r_ad  <= (FIELD_W+1)'(r_attack) + (FIELD_W+1)'(r_decay);
                r_adr <= (FIELD_W+2)'(r_attack) + (FIELD_W+2)'(r_decay)
                         + (FIELD_W+2)'(r_release);
            end
            S_ADS: begin
                // end of sustain: total minus release, or a + d when the phases overrun
                r_ads <= ((FIELD_W+2)'(r_total) > r_adr)
                         ? (FIELD_W+1)'(r_total - r_release) : r_ad;
            end
            S_SEL: begin
                if (w_in_att) begin
                    r_ma   <= w_x[FIELD_W-1:0];
                    r_mb   <= ONE_Q15;
                    r_den  <= r_attack;
                    r_dec  <= 1'b0;
                    r_skip <= 1'b0;
                    r_env  <= '0;
                end else if (w_in_dec) begin
                    r_ma   <= FIELD_W'(w_x - CMP_W'(r_attack));
                    r_mb   <= ONE_Q15 - w_level;
                    r_den  <= r_decay;
                    r_dec  <= 1'b1;
                    r_skip <= 1'b0;
                    r_env  <= '0;
                end else if (w_in_sus) begin
                    r_ma   <= '0;
                    r_mb   <= '0;
                    r_den  <= r_release;
                    r_dec  <= 1'b0;
                    r_skip <= 1'b1;
                    r_env  <= w_level;
                end else if (w_rel_zero) begin
                    r_ma   <= '0;
                    r_mb   <= '0;
                    r_den  <= r_release;
                    r_dec  <= 1'b0;
                    r_skip <= 1'b1;
                    r_env  <= '0;
                end else begin
                    r_ma   <= w_level;
                    r_mb   <= r_release - w_k[FIELD_W-1:0];
                    r_den  <= r_release;
                    r_dec  <= 1'b0;
                    r_skip <= 1'b0;
                    r_env  <= '0;
                end
            end
            S_OMUL: begin
                // magnitude times gain, shifted down by 15
                r_pm <= w_prod[NUM_W-1:NUM_W-FIELD_W];
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
            // restore the sign; truncation toward zero falls out of scaling the magnitude
            r_sample_out <= r_neg ? FIELD_W'(FIELD_W'(0) - r_pm) : r_pm;
            r_last_out   <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = $signed(r_sample_out);
    assign o_last       = r_last_out;

    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_div_stat.busy)
        else $error("input ready while divider busy");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_restart_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_restart && !w_acc_last) |=> (r_pos == COUNT_BITS'(1)))
        else $error("restart did not move position to one");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && r_out_valid && !i_out_ready) |=> (r_state == S_DONE))
        else $error("result left while output register full");

endmodule

`default_nettype wire
